@@ hdl/sss_pkg.sv @@
package sss_pkg;

  localparam int SAMPLE_SHIFT = 8;
  localparam int WORD_W       = 32;
  localparam int SAMPLE_W     = 24;
  localparam int CNT_W        = 32;
  localparam int SUM_W        = 56;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Operation codes of an input word.
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  // Slot codes.
  localparam logic SLOT_LEFT  = 1'b0;
  localparam logic SLOT_RIGHT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic                     slot;
    logic signed [WORD_W-1:0] raw_word;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]           count;
    logic [CNT_W-1:0]           nonzero_count;
    logic [CNT_W-1:0]           change_count;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [SUM_W-1:0]           abs_total;
  } slot_stats_t;

  typedef struct packed {
    logic                       slot_id;
    logic [CNT_W-1:0]           count;
    logic [CNT_W-1:0]           nonzero_count;
    logic [CNT_W-1:0]           change_count;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [SUM_W-1:0]           abs_total;
    logic                       last;
  } out_word_t;

endpackage

@@ hdl/sss_slot_stats.sv @@
module sss_slot_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                add_en,
  input  logic                                clr,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
  output sss_pkg::slot_stats_t                stats
);
  import sss_pkg::*;

  logic [CNT_W-1:0]           tally_r, tally_nxt;
  logic [CNT_W-1:0]           nonzero_r, nonzero_nxt;
  logic [CNT_W-1:0]           change_r, change_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] prior_r, prior_nxt;
  logic                       prior_valid_r, prior_valid_nxt;
  logic [SAMPLE_W-1:0]        magnitude;
  logic                       empty;

  // Magnitude of the most negative sample still fits as an unsigned value.
  assign magnitude = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

  always_comb begin
    tally_nxt       = tally_r;
    nonzero_nxt     = nonzero_r;
    change_nxt      = change_r;
    min_nxt         = min_r;
    max_nxt         = max_r;
    sum_nxt         = sum_r;
    prior_nxt       = prior_r;
    prior_valid_nxt = prior_valid_r;
    if (clr) begin
      tally_nxt       = '0;
      nonzero_nxt     = '0;
      change_nxt      = '0;
      min_nxt         = SAMPLE_MAX;
      max_nxt         = SAMPLE_MIN;
      sum_nxt         = '0;
      prior_nxt       = '0;
      prior_valid_nxt = 1'b0;
    end else if (add_en) begin
      tally_nxt = tally_r + 1'b1;
      if (sample != '0) begin
        nonzero_nxt = nonzero_r + 1'b1;
      end
      if (prior_valid_r && (sample != prior_r)) begin
        change_nxt = change_r + 1'b1;
      end
      if (sample < min_r) begin
        min_nxt = sample;
      end
      if (sample > max_r) begin
        max_nxt = sample;
      end
      sum_nxt         = sum_r + {{(SUM_W-SAMPLE_W){1'b0}}, magnitude};
      prior_nxt       = sample;
      prior_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r       <= '0;
      nonzero_r     <= '0;
      change_r      <= '0;
      min_r         <= SAMPLE_MAX;
      max_r         <= SAMPLE_MIN;
      sum_r         <= '0;
      prior_r       <= '0;
      prior_valid_r <= 1'b0;
    end else begin
      tally_r       <= tally_nxt;
      nonzero_r     <= nonzero_nxt;
      change_r      <= change_nxt;
      min_r         <= min_nxt;
      max_r         <= max_nxt;
      sum_r         <= sum_nxt;
      prior_r       <= prior_nxt;
      prior_valid_r <= prior_valid_nxt;
    end
  end

  // Extremes read zero whenever the sample count is zero, also after a wrap.
  assign empty = (tally_r == '0);

  always_comb begin
    stats.count         = tally_r;
    stats.nonzero_count = nonzero_r;
    stats.change_count  = change_r;
    stats.min_value     = empty ? '0 : min_r;
    stats.max_value     = empty ? '0 : max_r;
    stats.abs_total     = sum_r;
  end

endmodule

@@ hdl/sss_snap_buf.sv @@
module sss_snap_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sss_pkg::out_word_t first_word,
  input  sss_pkg::out_word_t second_word,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output sss_pkg::out_word_t out_word
);
  import sss_pkg::*;

  out_word_t   first_r, second_r;
  logic [1:0]  pending_r, pending_nxt;
  logic        take;

  assign out_valid = (pending_r != 2'd0);
  assign take      = out_valid && !out_stall;
  // Room for a new pair once the last word of the current pair leaves.
  assign free      = (pending_r == 2'd0) || ((pending_r == 2'd1) && take);
  assign out_word  = pending_r[1] ? first_r : second_r;

  always_comb begin
    pending_nxt = pending_r;
    if (load) begin
      pending_nxt = 2'd2;
    end else if (take) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_r  <= first_word;
      second_r <= second_word;
    end
  end

endmodule

@@ hdl/stereo_sample_statistics.sv @@
// Channel   Ports                          Direction  Word
// input     in_valid, in_stall, in_word    in         op, slot, raw_word
// result    out_valid, out_stall, out_word out        slot statistics
//
// A sample word updates its slot's statistics at the clock edge that accepts
// it; sample words can be accepted on every cycle.
// A snapshot word copies both slots into a two-word output buffer and clears
// the statistics at the same edge; the results then leave in turn, left first.
// Reset (rst_n low at a clock edge) clears all statistics and empties the buffer.
// Only a snapshot word can be stalled: it waits while the previous snapshot's
// results are still in the buffer, and the last of them leaving frees it.
module stereo_sample_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sss_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sss_pkg::out_word_t out_word
);
  import sss_pkg::*;

  logic                       accept;
  logic                       is_snapshot;
  logic                       buf_free;
  logic                       add_left;
  logic                       add_right;
  logic signed [SAMPLE_W-1:0] sample;
  slot_stats_t                left_stats;
  slot_stats_t                right_stats;
  out_word_t                  left_word;
  out_word_t                  right_word;

  // A snapshot needs both buffer entries; sample words never wait.
  assign is_snapshot = (in_word.op == OP_SNAPSHOT);
  assign in_stall    = is_snapshot && !buf_free;
  assign accept      = in_valid && !in_stall;

  // The sample sits in the upper bits of the slot word.
  assign sample = in_word.raw_word[WORD_W-1:SAMPLE_SHIFT];

  assign add_left  = accept && !is_snapshot && (in_word.slot == SLOT_LEFT);
  assign add_right = accept && !is_snapshot && (in_word.slot == SLOT_RIGHT);

  sss_slot_stats u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .add_en (add_left),
    .clr    (accept && is_snapshot),
    .sample (sample),
    .stats  (left_stats)
  );

  sss_slot_stats u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .add_en (add_right),
    .clr    (accept && is_snapshot),
    .sample (sample),
    .stats  (right_stats)
  );

  // The left slot goes out first, the right slot closes the snapshot.
  always_comb begin
    left_word.slot_id        = SLOT_LEFT;
    left_word.count          = left_stats.count;
    left_word.nonzero_count  = left_stats.nonzero_count;
    left_word.change_count   = left_stats.change_count;
    left_word.min_value      = left_stats.min_value;
    left_word.max_value      = left_stats.max_value;
    left_word.abs_total      = left_stats.abs_total;
    left_word.last           = 1'b0;

    right_word.slot_id       = SLOT_RIGHT;
    right_word.count         = right_stats.count;
    right_word.nonzero_count = right_stats.nonzero_count;
    right_word.change_count  = right_stats.change_count;
    right_word.min_value     = right_stats.min_value;
    right_word.max_value     = right_stats.max_value;
    right_word.abs_total     = right_stats.abs_total;
    right_word.last          = 1'b1;
  end

  sss_snap_buf u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept && is_snapshot),
    .first_word  (left_word),
    .second_word (right_word),
    .free        (buf_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule
